/* hw/rtl/lfipid_pkg.sv */
// ----------------------------------------------------------------------------
// lfipid_pkg: shared types and constants
// Item structs, phase, mode, state and register codes, fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lfipid_pkg;

    typedef struct packed {
        logic far_left_seen;
        logic left_seen;
        logic center_seen;
        logic right_seen;
        logic far_right_seen;
    } t_in_item;

    typedef struct packed {
        logic       left_reverse;
        logic [6:0] left_speed;
        logic       right_update;
        logic       right_reverse;
        logic [6:0] right_speed;
        logic       turn_done;
        logic [1:0] mode;
        logic       lost_line;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_BRAKE = 2'd0,
        PH_SPIN  = 2'd1,
        PH_STOP  = 2'd2,
        PH_SPARE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_BRAKE    = 2'd1,
        MODE_SPIN     = 2'd2,
        MODE_STOP     = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMOOTH_A,
        ST_SMOOTH_B,
        ST_PROP,
        ST_INTEG,
        ST_DFILT_A,
        ST_DFILT_B,
        ST_DERIV,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_INTEG_SEP   = 3'd3,
        REG_DERIV_SMOOTH = 3'd4,
        REG_STEP_UPPER  = 3'd5,
        REG_STEP_LOWER  = 3'd6,
        REG_BASE_SPEED  = 3'd7
    } t_reg_idx;

    localparam int CFG_DW = 16;
    localparam int CFG_AW = 4;

    localparam logic [12:0] SMOOTH_OLD = 13'd2867;
    localparam logic [12:0] SMOOTH_NEW = 13'd1229;
    localparam logic [12:0] ALPHA_MAX  = 13'd4096;
    localparam logic [1:0]  CENTER_EXIT_HITS = 2'd3;
    localparam logic [6:0]  SPIN_SPEED = 7'd37;
    localparam logic [6:0]  STOP_SPEED = 7'd120;
    localparam logic [6:0]  SPEED_MAX  = 7'd99;
    localparam logic signed [6:0] LOST_BIAS = 7'sd50;
    localparam logic signed [39:0] SPEED_MAX_Q = 40'sd6488064;  // 99.0
    localparam logic signed [39:0] DEADZONE_Q  = 40'sd262144;   // 4.0
    localparam logic signed [39:0] LIMIT_LOST_Q = 40'sd1638400; // 25.0
    localparam logic signed [39:0] LIMIT_NORM_Q = 40'sd983040;  // 15.0

endpackage

`default_nettype wire

/* hw/rtl/lfipid_mac.sv */
// ----------------------------------------------------------------------------
// lfipid_mac: shared multiply-accumulate unit
// Signed 16x40 product added to a 56-bit accumulator, registered; rounds to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module lfipid_mac
    import lfipid_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_clear,
    input  wire logic                i_en,
    input  wire logic signed [15:0]  i_coef,
    input  wire logic signed [39:0]  i_data,
    output logic signed [39:0]       o_round
);

    logic signed [55:0] r_acc;
    logic signed [55:0] n_acc;
    logic signed [55:0] w_prod;
    logic signed [55:0] w_base;
    logic signed [55:0] w_rnd;

    assign w_prod = 56'(i_coef) * 56'(i_data);
    assign w_base = i_clear ? 56'sd0 : r_acc;
    assign n_acc  = w_base + w_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    // round to nearest: add half an lsb, then floor shift by 12
    assign w_rnd   = r_acc + 56'sd2048;
    assign o_round = w_rnd[51:12];

endmodule

`default_nettype wire

/* hw/rtl/line_follower_incremental_pid_core.sv */
// ----------------------------------------------------------------------------
// line_follower_incremental_pid_core: line follower steering controller
// Sensor decode, left-turn sequencer and incremental PID on one shared MAC.
// Straight mode runs the smoothing, proportional, integral, derivative
//   filter and derivative states, seven passes on the shared MAC, then the
//   finish and output states; turn phases register the result from idle.
// Input ready drops while an item is in work; the result register frees it.
// Reset (synchronous, active low) loads default gains, clears control state.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_incremental_pid_core
    import lfipid_pkg::*;
#(
    parameter int TURN_TIMEOUT   = 1000,
    parameter int COOLDOWN_TICKS = 500,
    parameter int BRAKE_TICKS    = 15,
    parameter int SPIN_MIN_TICKS = 200
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_in_item          i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_out_item              o_item,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    // configuration registers
    logic [14:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [6:0]  r_integ_sep, r_base_speed;
    logic [12:0] r_deriv_smooth;
    logic signed [15:0] r_step_upper, r_step_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= 15'd9011;
            r_integ_gain   <= 15'd82;
            r_deriv_gain   <= 15'd1434;
            r_integ_sep    <= 7'd12;
            r_deriv_smooth <= 13'd2867;
            r_step_upper   <= 16'sd768;
            r_step_lower   <= -16'sd768;
            r_base_speed   <= 7'd41;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                4'(REG_PROP_GAIN):    r_prop_gain    <= i_cfg_data[14:0];
                4'(REG_INTEG_GAIN):   r_integ_gain   <= i_cfg_data[14:0];
                4'(REG_DERIV_GAIN):   r_deriv_gain   <= i_cfg_data[14:0];
                4'(REG_INTEG_SEP):    r_integ_sep    <= i_cfg_data[6:0];
                4'(REG_DERIV_SMOOTH): r_deriv_smooth <= i_cfg_data[12:0];
                4'(REG_STEP_UPPER):   r_step_upper   <= i_cfg_data;
                4'(REG_STEP_LOWER):   r_step_lower   <= i_cfg_data;
                4'(REG_BASE_SPEED):   r_base_speed   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // controller state
    t_state r_state, n_state;
    logic   r_turning, n_turning;
    t_phase r_phase, n_phase;
    logic [10:0] r_ph_ticks, n_ph_ticks;
    logic [8:0]  r_cool, n_cool;
    logic [1:0]  r_hits, n_hits;
    logic        r_lost, n_lost;
    logic signed [6:0] r_last_good, n_last_good, r_raw, n_raw;
    // Q16.16 values held at 40 bits so increments and sums never wrap
    logic signed [39:0] r_smooth, n_smooth;
    logic signed [39:0] r_prev, n_prev, r_prev2, n_prev2;
    logic signed [39:0] r_dfilt, n_dfilt, r_steer, n_steer;
    logic signed [39:0] r_w, n_w, r_delta, n_delta;
    logic r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // shared MAC control
    logic               w_mac_clear, w_mac_en;
    logic signed [15:0] w_coef;
    logic signed [39:0] w_data, w_round;

    lfipid_mac u_mac (
        .i_clk   (i_clk),
        .i_clear (w_mac_clear),
        .i_en    (w_mac_en),
        .i_coef  (w_coef),
        .i_data  (w_data),
        .o_round (w_round)
    );

    assign o_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    logic signed [39:0] w_raw_q, w_abs_w, w_sep_q, w_dr, w_up, w_lo, w_sum, w_lim;
    logic signed [39:0] w_lsum, w_rsum;
    logic [12:0] w_alpha;
    logic [2:0]  w_inner;
    logic [4:0]  w_all;

    function automatic logic [6:0] wheel(input logic signed [39:0] q);
        logic [6:0] v;
        if (q > SPEED_MAX_Q) v = SPEED_MAX;
        else if (q < 0)      v = 7'd0;
        else                 v = q[22:16];
        return v;
    endfunction

    assign w_raw_q = 40'(r_raw) <<< 16;
    assign w_abs_w = (r_w < 0) ? -r_w : r_w;
    assign w_sep_q = 40'({r_integ_sep, 16'd0});
    assign w_dr    = r_w - (r_prev <<< 1) + r_prev2;
    assign w_alpha = (r_deriv_smooth > ALPHA_MAX) ? ALPHA_MAX : r_deriv_smooth;
    assign w_up    = 40'(r_step_upper) <<< 8;
    assign w_lo    = 40'(r_step_lower) <<< 8;
    assign w_lim   = r_lost ? LIMIT_LOST_Q : LIMIT_NORM_Q;
    assign w_inner = {i_item.left_seen, i_item.center_seen, i_item.right_seen};
    assign w_all   = i_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_turning   <= 1'b0;
            r_phase     <= PH_BRAKE;
            r_ph_ticks  <= '0;
            r_cool      <= '0;
            r_hits      <= '0;
            r_lost      <= 1'b0;
            r_last_good <= '0;
            r_raw       <= '0;
            r_smooth    <= '0;
            r_prev      <= '0;
            r_prev2     <= '0;
            r_dfilt     <= '0;
            r_steer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_turning   <= n_turning;
            r_phase     <= n_phase;
            r_ph_ticks  <= n_ph_ticks;
            r_cool      <= n_cool;
            r_hits      <= n_hits;
            r_lost      <= n_lost;
            r_last_good <= n_last_good;
            r_raw       <= n_raw;
            r_smooth    <= n_smooth;
            r_prev      <= n_prev;
            r_prev2     <= n_prev2;
            r_dfilt     <= n_dfilt;
            r_steer     <= n_steer;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_delta <= n_delta;
        r_out   <= n_out;
    end

    always_comb begin
        n_state = r_state;   n_turning = r_turning; n_phase = r_phase;
        n_ph_ticks = r_ph_ticks; n_cool = r_cool; n_hits = r_hits;
        n_lost = r_lost; n_last_good = r_last_good; n_raw = r_raw;
        n_smooth = r_smooth; n_prev = r_prev; n_prev2 = r_prev2;
        n_dfilt = r_dfilt; n_steer = r_steer; n_w = r_w; n_delta = r_delta;
        n_out_valid = r_out_valid; n_out = r_out;
        w_mac_clear = 1'b1; w_mac_en = 1'b0; w_coef = '0; w_data = '0;
        w_sum = '0; w_lsum = '0; w_rsum = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    // sensor step
                    if (!i_item.far_left_seen && !r_turning && r_cool == '0) begin
                        n_turning = 1'b1; n_phase = PH_BRAKE; n_ph_ticks = '0;
                        n_hits = '0; n_steer = '0; n_prev = '0; n_prev2 = '0;
                        n_lost = 1'b0;
                    end else if (w_all == '0) begin
                        n_lost = 1'b1;
                        n_raw  = (r_last_good >= 0) ? LOST_BIAS : -LOST_BIAS;
                    end else begin
                        if (r_lost) begin
                            n_lost = 1'b0; n_steer = '0; n_prev = '0; n_prev2 = '0;
                            n_dfilt = '0;
                        end
                        case (w_inner)
                            3'b010: begin n_raw = 7'sd0;   n_last_good = 7'sd0;   end
                            3'b110: begin n_raw = -7'sd10; n_last_good = -7'sd10; end
                            3'b011: begin n_raw = 7'sd10;  n_last_good = 7'sd10;  end
                            3'b100: begin n_raw = -7'sd30; n_last_good = -7'sd30; end
                            3'b001: begin n_raw = 7'sd30;  n_last_good = 7'sd30;  end
                            default: ;
                        endcase
                    end
                    n_out = '0;
                    // turn phases act on the state as it stands after the sensor step
                    if (n_turning) begin
                        n_ph_ticks = n_ph_ticks + 11'd1;
                        n_out.lost_line = n_lost;
                        case (n_phase)
                            PH_BRAKE: begin
                                n_out.left_reverse = 1'b1; n_out.left_speed = r_base_speed;
                                n_out.right_update = 1'b1; n_out.right_reverse = 1'b1;
                                n_out.right_speed = r_base_speed;
                                n_out.mode = MODE_BRAKE;
                                if (n_ph_ticks >= 11'(BRAKE_TICKS)) begin
                                    n_phase = PH_SPIN; n_ph_ticks = '0;
                                end
                            end
                            PH_SPIN: begin
                                n_out.right_update = 1'b1; n_out.right_speed = SPIN_SPEED;
                                n_out.mode = MODE_SPIN;
                                if (n_ph_ticks > 11'(SPIN_MIN_TICKS)) begin
                                    if (!i_item.center_seen) begin
                                        n_hits = r_hits + 2'd1;
                                        if (n_hits >= CENTER_EXIT_HITS) begin
                                            n_phase = PH_STOP;
                                        end
                                    end else begin
                                        n_hits = '0;
                                    end
                                end
                                if (n_phase == PH_STOP
                                    || n_ph_ticks >= 11'(TURN_TIMEOUT)) begin
                                    n_phase = PH_STOP; n_ph_ticks = '0;
                                end
                            end
                            default: begin
                                n_out.left_reverse = 1'b1; n_out.left_speed = STOP_SPEED;
                                n_out.mode = MODE_STOP;
                                if (n_ph_ticks >= 11'(BRAKE_TICKS)) begin
                                    n_out.turn_done = 1'b1;
                                    n_turning = 1'b0; n_phase = PH_BRAKE; n_ph_ticks = '0;
                                    n_cool = 9'(COOLDOWN_TICKS);
                                    n_steer = '0; n_prev = '0; n_prev2 = '0;
                                    n_last_good = '0; n_smooth = '0; n_dfilt = '0;
                                    n_raw = '0; n_hits = '0;
                                end
                            end
                        endcase
                        n_out_valid = 1'b1;
                    end else begin
                        if (r_cool != '0) n_cool = r_cool - 9'd1;
                        n_state = ST_SMOOTH_A;
                    end
                end
            end
            // smoothed = round((old*2867 + raw*1229) / 4096)
            ST_SMOOTH_A: begin
                w_mac_en = 1'b1; w_coef = 16'(SMOOTH_OLD); w_data = r_smooth;
                n_state = ST_SMOOTH_B;
            end
            ST_SMOOTH_B: begin
                w_mac_en = 1'b1; w_mac_clear = 1'b0;
                w_coef = 16'(SMOOTH_NEW); w_data = w_raw_q;
                n_state = ST_PROP;
            end
            ST_PROP: begin
                // pick the working error and start the proportional term
                if (!r_lost) begin
                    n_smooth = w_round;
                    if (((w_round < 0) ? -w_round : w_round) <= DEADZONE_Q) n_w = '0;
                    else n_w = w_round;
                end else begin
                    n_w = w_raw_q;
                end
                w_mac_en = 1'b1; w_coef = 16'(r_prop_gain); w_data = n_w - r_prev;
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                n_delta = w_round;
                w_mac_en = 1'b1;
                w_coef = (w_abs_w < w_sep_q) ? 16'(r_integ_gain) : 16'sd0;
                w_data = r_w;
                n_state = ST_DFILT_A;
            end
            ST_DFILT_A: begin
                n_delta = r_delta + w_round;
                w_mac_en = 1'b1; w_coef = 16'(w_alpha); w_data = r_dfilt;
                n_state = ST_DFILT_B;
            end
            ST_DFILT_B: begin
                w_mac_en = 1'b1; w_mac_clear = 1'b0;
                w_coef = 16'(ALPHA_MAX - w_alpha); w_data = w_dr;
                n_state = ST_DERIV;
            end
            ST_DERIV: begin
                n_dfilt = w_round;
                w_mac_en = 1'b1; w_coef = 16'(r_deriv_gain); w_data = w_round;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                w_sum = r_delta + w_round;
                if (w_sum > w_up)      w_sum = w_up;
                else if (w_sum < w_lo) w_sum = w_lo;
                n_steer = r_steer + w_sum;
                if (n_steer > w_lim)       n_steer = w_lim;
                else if (n_steer < -w_lim) n_steer = -w_lim;
                n_prev2 = r_prev; n_prev = r_w;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // drive the wheels differentially about the base speed
                w_lsum = (40'({r_base_speed, 16'd0})) + r_steer;
                w_rsum = (40'({r_base_speed, 16'd0})) - r_steer;
                n_out = '0;
                n_out.left_speed   = wheel(w_lsum);
                n_out.right_speed  = wheel(w_rsum);
                n_out.right_update = 1'b1;
                n_out.mode         = MODE_STRAIGHT;
                n_out.lost_line    = r_lost;
                n_out_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire
